// ===== sv/lpcsv_pkg.sv =====
// Shared types and constants of the length-prefixed CSV record parser.
package lpcsv_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PREFIX_SIZE   = 2'd0;
   localparam logic [1:0] CSR_PREFIX_FORMAT = 2'd1;
   localparam logic [1:0] CSR_DELIMITER     = 2'd2;

   // Prefix formats.
   localparam logic FORMAT_ASCII  = 1'b0;
   localparam logic FORMAT_BINARY = 1'b1;

   // Character codes.
   localparam logic [7:0] QUOTE_CHAR = 8'd34;
   localparam logic [7:0] SPACE_CHAR = 8'd32;
   localparam logic [7:0] DIGIT_ZERO = 8'd48;
   localparam logic [7:0] DIGIT_NINE = 8'd57;

   // Prefix size limits.
   localparam logic [3:0] PREFIX_SIZE_MIN = 4'd1;
   localparam logic [3:0] PREFIX_SIZE_MAX = 4'd8;

   // Quote state of the current field.
   typedef enum logic [1:0] {
      QM_PLAIN      = 2'd0,
      QM_QUOTED     = 2'd1,
      QM_QUOTE_SEEN = 2'd2
   } quote_mode_type;

   // Configuration registers.
   typedef struct packed {
      logic [3:0] prefix_size;
      logic       prefix_format;
      logic [7:0] delimiter;
   } cfg_type;

   // Progress through the length prefix.
   typedef struct packed {
      logic [3:0] count;
      logic       digits_seen;
      logic       digits_stopped;
   } prefix_flags_type;

   // One result item.
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       field_end;
      logic       record_end;
      logic [7:0] field_number;
      logic       length_error;
   } rsp_type;

endpackage

// ===== sv/length_prefixed_csv_record_parser.sv =====
// Top level of the length-prefixed CSV record parser.
//
// Requests carry one byte of a record stream on req_data_byte. Each record is
// a length prefix of prefix_size bytes (ASCII decimal or binary little-endian)
// followed by that many body bytes, which are split into CSV fields.
// Responses on the rsp_ channel carry a content byte, field and record end
// flags, the field index, or a length error for a prefix without digits.
// Non-final prefix bytes, opening quotes and dropped bytes give no response.
// The csr_ channel writes prefix_size, prefix_format and delimiter; it is
// always ready and should be used only while no request is in flight.
// A request goes into an input register, then through the per-byte logic
// into the response register. One request is accepted every cycle while
// the receiver does not stall; the prefix and quote state is updated as
// each byte is taken from the input register by the per-byte logic.
// When the receiver stalls, the response register holds, and one more
// request waits in the input register before req_ready drops.
// Synchronous reset empties both registers, restores the register defaults
// and returns the parser to the start of a length prefix.
module length_prefixed_csv_record_parser import lpcsv_pkg::*; #(
   parameter int MAX_FIELDS  = 256,
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_char_valid,
   output logic [7:0] rsp_char_out,
   output logic       rsp_field_end,
   output logic       rsp_record_end,
   output logic [7:0] rsp_field_number,
   output logic       rsp_length_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type                cfg_ff;
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   advance;

   logic                   in_body_ff, in_body_in;
   prefix_flags_type       flags_ff, flags_in;
   logic [LENGTH_BITS-1:0] accum_ff, accum_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   quote_mode_type         quote_mode_ff, quote_mode_in;
   logic [7:0]             field_ff, field_in;

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   has_result;

   prefix_flags_type       p_flags;
   logic [LENGTH_BITS-1:0] p_accum;
   logic                   p_done;
   logic                   p_error;

   quote_mode_type         b_quote;
   logic [LENGTH_BITS-1:0] b_bytes_left;
   logic [7:0]             b_field;
   logic                   b_last;
   logic                   b_has;
   rsp_type                b_result;

   // The input register moves on when the response register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   lpcsv_prefix #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_prefix (
      .cfg          (cfg_ff),
      .flags        (flags_ff),
      .accum        (accum_ff),
      .data_byte    (in_byte_ff),
      .flags_next   (p_flags),
      .accum_next   (p_accum),
      .done         (p_done),
      .length_error (p_error)
   );

   lpcsv_body #(
      .MAX_FIELDS  (MAX_FIELDS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_body (
      .delimiter       (cfg_ff.delimiter),
      .quote_mode      (quote_mode_ff),
      .bytes_left      (bytes_left_ff),
      .field_counter   (field_ff),
      .data_byte       (in_byte_ff),
      .quote_next      (b_quote),
      .bytes_left_next (b_bytes_left),
      .field_next      (b_field),
      .last            (b_last),
      .has_result      (b_has),
      .result          (b_result)
   );

   // Next parser state and response for the byte in the input register.
   always_comb begin
      in_body_in    = in_body_ff;
      flags_in      = flags_ff;
      accum_in      = accum_ff;
      bytes_left_in = bytes_left_ff;
      quote_mode_in = quote_mode_ff;
      field_in      = field_ff;
      rsp_in        = '0;
      has_result    = 1'b0;
      if (!in_body_ff) begin
         flags_in = p_flags;
         accum_in = p_accum;
         if (p_done) begin
            flags_in = '0;
            accum_in = '0;
            if (p_error) begin
               rsp_in.length_error = 1'b1;
               has_result          = 1'b1;
            end else begin
               bytes_left_in = p_accum;
               quote_mode_in = QM_PLAIN;
               field_in      = 8'd0;
               if (p_accum == '0) begin
                  // Empty record: one closing response.
                  rsp_in.field_end  = 1'b1;
                  rsp_in.record_end = 1'b1;
                  has_result        = 1'b1;
               end else begin
                  in_body_in = 1'b1;
               end
            end
         end
      end else begin
         bytes_left_in = b_bytes_left;
         quote_mode_in = b_quote;
         field_in      = b_field;
         rsp_in        = b_result;
         has_result    = b_has;
         if (b_last) begin
            in_body_in    = 1'b0;
            flags_in      = '0;
            accum_in      = '0;
            quote_mode_in = QM_PLAIN;
         end
      end
   end

   // Control state: input and response valid, parser state, configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         in_body_ff           <= 1'b0;
         flags_ff             <= '0;
         accum_ff             <= '0;
         bytes_left_ff        <= '0;
         quote_mode_ff        <= QM_PLAIN;
         field_ff             <= 8'd0;
         cfg_ff.prefix_size   <= 4'd4;
         cfg_ff.prefix_format <= FORMAT_ASCII;
         cfg_ff.delimiter     <= 8'd44;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff  <= has_result;
            in_body_ff    <= in_body_in;
            flags_ff      <= flags_in;
            accum_ff      <= accum_in;
            bytes_left_ff <= bytes_left_in;
            quote_mode_ff <= quote_mode_in;
            field_ff      <= field_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_PREFIX_SIZE:   cfg_ff.prefix_size   <= csr_data[3:0];
               CSR_PREFIX_FORMAT: cfg_ff.prefix_format <= csr_data[0];
               CSR_DELIMITER:     cfg_ff.delimiter     <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_char_valid   = rsp_ff.char_valid;
   assign rsp_char_out     = rsp_ff.char_out;
   assign rsp_field_end    = rsp_ff.field_end;
   assign rsp_record_end   = rsp_ff.record_end;
   assign rsp_field_number = rsp_ff.field_number;
   assign rsp_length_error = rsp_ff.length_error;

endmodule

// ===== sv/lpcsv_prefix.sv =====
// Length prefix decoder: folds one prefix byte into the length accumulator.
module lpcsv_prefix import lpcsv_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  cfg_type                cfg,
   input  prefix_flags_type       flags,
   input  logic [LENGTH_BITS-1:0] accum,
   input  logic [7:0]             data_byte,
   output prefix_flags_type       flags_next,
   output logic [LENGTH_BITS-1:0] accum_next,
   output logic                   done,
   output logic                   length_error
);

   logic [3:0]             size_eff;
   logic [31:0]            shifted;
   logic [LENGTH_BITS+3:0] decimal;
   logic [LENGTH_BITS+3:0] accum_wide;
   logic                   is_digit;

   // Prefix size clamped to the supported range.
   always_comb begin
      if (cfg.prefix_size < PREFIX_SIZE_MIN) begin
         size_eff = PREFIX_SIZE_MIN;
      end else if (cfg.prefix_size > PREFIX_SIZE_MAX) begin
         size_eff = PREFIX_SIZE_MAX;
      end else begin
         size_eff = cfg.prefix_size;
      end
   end

   // Binary byte placed at its little-endian position.
   assign shifted = {24'd0, data_byte} << {flags.count[1:0], 3'b000};

   // Decimal step: accum * 10 + digit, saturated at the maximum on overflow.
   assign is_digit   = (data_byte >= DIGIT_ZERO) && (data_byte <= DIGIT_NINE);
   assign accum_wide = {4'd0, accum};
   assign decimal    = (accum_wide << 3) + (accum_wide << 1)
                     + (LENGTH_BITS+4)'(data_byte - DIGIT_ZERO);

   // Accumulator and digit tracking.
   always_comb begin
      flags_next       = flags;
      accum_next       = accum;
      flags_next.count = flags.count + 4'd1;
      if (cfg.prefix_format == FORMAT_BINARY) begin
         if (flags.count[3:2] == 2'b00) begin
            accum_next = accum | shifted[LENGTH_BITS-1:0];
         end
      end else if (!flags.digits_stopped) begin
         if (is_digit) begin
            if (decimal[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
               accum_next = '1;
            end else begin
               accum_next = decimal[LENGTH_BITS-1:0];
            end
            flags_next.digits_seen = 1'b1;
         end else if (!((data_byte == SPACE_CHAR) && !flags.digits_seen)) begin
            flags_next.digits_stopped = 1'b1;
         end
      end
   end

   // The last prefix byte closes the prefix; an ASCII prefix needs a digit.
   assign done = ({1'b0, flags.count} + 5'd1) >= {1'b0, size_eff};
   assign length_error = done && (cfg.prefix_format == FORMAT_ASCII)
                       && !flags_next.digits_seen;

endmodule

// ===== sv/lpcsv_body.sv =====
// Record body splitter: quote handling, field counting and record end.
module lpcsv_body import lpcsv_pkg::*; #(
   parameter int MAX_FIELDS  = 256,
   parameter int LENGTH_BITS = 32
) (
   input  logic [7:0]             delimiter,
   input  quote_mode_type         quote_mode,
   input  logic [LENGTH_BITS-1:0] bytes_left,
   input  logic [7:0]             field_counter,
   input  logic [7:0]             data_byte,
   output quote_mode_type         quote_next,
   output logic [LENGTH_BITS-1:0] bytes_left_next,
   output logic [7:0]             field_next,
   output logic                   last,
   output logic                   has_result,
   output rsp_type                result
);

   localparam int FIELD_CAP = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

   logic char_hit;
   logic field_hit;

   // Remaining body length.
   always_comb begin
      if (bytes_left != '0) begin
         bytes_left_next = bytes_left - LENGTH_BITS'(1);
      end else begin
         bytes_left_next = bytes_left;
      end
   end
   assign last = (bytes_left_next == '0);

   // Quote state machine for one byte.
   always_comb begin
      quote_next = QM_PLAIN;
      char_hit   = 1'b0;
      field_hit  = 1'b0;
      case (quote_mode)
         QM_QUOTED: begin
            if (data_byte == QUOTE_CHAR) begin
               quote_next = QM_QUOTE_SEEN;
            end else begin
               char_hit   = 1'b1;
               quote_next = QM_QUOTED;
            end
         end
         QM_QUOTE_SEEN: begin
            if (data_byte == delimiter) begin
               field_hit = 1'b1;
            end else if (data_byte == QUOTE_CHAR) begin
               char_hit   = 1'b1;
               quote_next = QM_QUOTED;
            end
         end
         default: begin
            if (data_byte == delimiter) begin
               field_hit = 1'b1;
            end else if (data_byte == QUOTE_CHAR) begin
               quote_next = QM_QUOTED;
            end else begin
               char_hit = 1'b1;
            end
         end
      endcase
   end

   // Field index, reset at record end and saturating at the cap.
   always_comb begin
      field_next = field_counter;
      if (last) begin
         field_next = 8'd0;
      end else if (field_hit && (field_counter < 8'(FIELD_CAP))) begin
         field_next = field_counter + 8'd1;
      end
   end

   // Result item for this byte.
   always_comb begin
      result.char_valid   = char_hit;
      result.char_out     = char_hit ? data_byte : 8'd0;
      result.field_end    = last || field_hit;
      result.record_end   = last;
      result.field_number = field_counter;
      result.length_error = 1'b0;
   end
   assign has_result = last || field_hit || char_hit;

endmodule
